>>> sv/kfgt_pkg.sv
// ----------------------------------------------------------------------------
// kfgt_pkg
// Shared types and constants for the keyframe index with gap thinning.
// ----------------------------------------------------------------------------
package kfgt_pkg;

  localparam int unsigned CapacityDef = 32;
  localparam int unsigned FrameW      = 64;
  localparam int unsigned CountW      = 6;
  localparam int unsigned ModeW       = 3;

  localparam logic [ModeW-1:0] ModeInsert = 3'd0;
  localparam logic [ModeW-1:0] ModeSeek   = 3'd1;
  localparam logic [ModeW-1:0] ModeLookup = 3'd2;
  localparam logic [ModeW-1:0] ModeInval  = 3'd3;
  localparam logic [ModeW-1:0] ModeClear  = 3'd4;

  // result kinds
  localparam logic KindDone  = 1'b0;
  localparam logic KindEvict = 1'b1;

  typedef struct packed {
    logic [ModeW-1:0]  mode;
    logic [FrameW-1:0] frame;
  } kfgt_in_t;

  typedef struct packed {
    logic              kind;
    logic              found;
    logic [FrameW-1:0] key_frame;
    logic [FrameW-1:0] distance;
    logic [CountW-1:0] removed_count;
    logic [CountW-1:0] entry_count;
    logic              refused;
    logic              last;
  } kfgt_out_t;

endpackage

>>> sv/kfgt_store.sv
// ----------------------------------------------------------------------------
// kfgt_store
// Key memory: one write port, one registered read port.
// ----------------------------------------------------------------------------
module kfgt_store import kfgt_pkg::*; #(
  parameter int unsigned Capacity = CapacityDef,
  parameter int unsigned AddrW    = $clog2(Capacity)
) (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [AddrW-1:0]  waddr_i,
  input  logic [FrameW-1:0] wdata_i,
  input  logic [AddrW-1:0]  raddr_i,
  output logic [FrameW-1:0] rdata_o
);

  logic [FrameW-1:0] mem_q [Capacity];

  // write and registered read
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

>>> sv/keyframe_index_gap_thinning.sv
// ----------------------------------------------------------------------------
// keyframe_index_gap_thinning
// Sorted keyframe set with seek, lookup, invalidate, clear and
// smallest-gap thinning on insert.
// ----------------------------------------------------------------------------
//  channel | signals                     | handshake
//  in      | start_i, busy_o, in_i       | taken when start_i & !busy_o
//  out     | res_valid_o, res_o          | one-cycle strobe, no stall
//  cfg     | cfg_valid_i, cfg_ready_o,   | written when valid & ready
//          | cfg_data_i                  |
//
// Every operation walks the key memory through its single read port, with
// an address state and a registered-data state per entry. Insert adds a
// shift pass over the moved entries, and each eviction a gap scan plus a
// removal shift. Reset clears the count and limit; key memory needs no
// clearing. The receiver cannot stall; busy_o stays high until the
// completion result.
// ----------------------------------------------------------------------------
module keyframe_index_gap_thinning import kfgt_pkg::*; #(
  parameter int unsigned Capacity = CapacityDef
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  output logic              busy_o,
  input  kfgt_in_t          in_i,
  output logic              res_valid_o,
  output kfgt_out_t         res_o,
  input  logic              cfg_valid_i,
  output logic              cfg_ready_o,
  input  logic [CountW-1:0] cfg_data_i
);

  localparam int unsigned AddrW = $clog2(Capacity);
  localparam int unsigned CntW  = $clog2(Capacity + 1);
  localparam logic [CntW-1:0] CapCnt = CntW'(Capacity);

  localparam logic [3:0] StIdle  = 4'd0;
  localparam logic [3:0] StSrchA = 4'd1;
  localparam logic [3:0] StSrchD = 4'd2;
  localparam logic [3:0] StDecide = 4'd3;
  localparam logic [3:0] StInsA  = 4'd4;
  localparam logic [3:0] StInsD  = 4'd5;
  localparam logic [3:0] StThin  = 4'd6;
  localparam logic [3:0] StGapA  = 4'd7;
  localparam logic [3:0] StGapD  = 4'd8;
  localparam logic [3:0] StRemA  = 4'd9;
  localparam logic [3:0] StRemD  = 4'd10;
  localparam logic [3:0] StDone  = 4'd11;

  logic [3:0]        state_q, state_d;
  logic [ModeW-1:0]  mode_q;
  logic [FrameW-1:0] frame_q;
  logic [CntW-1:0]   count_q, count_d;
  logic [CountW-1:0] maxk_q;
  logic [CntW-1:0]   idx_q, idx_d;     // scan / shift index
  logic [CntW-1:0]   pos_q, pos_d;     // keys <= frame
  logic [FrameW-1:0] prev_q, prev_d;   // last key read (pos-1, or lo)
  logic [FrameW-1:0] anchor_q, anchor_d;
  logic [FrameW-1:0] best_q, best_d;
  logic              vict_ok_q, vict_ok_d;
  logic [CntW-1:0]   vict_q, vict_d;
  logic [FrameW-1:0] vkey_q, vkey_d;
  logic [CntW-1:0]   removed_q, removed_d;
  logic              exists_q, exists_d;

  logic              we;
  logic [AddrW-1:0]  waddr, raddr;
  logic [FrameW-1:0] wdata, rdata;

  kfgt_out_t         res_d;
  logic              rv_d;

  kfgt_store #(.Capacity(Capacity), .AddrW(AddrW)) u_store (
    .clk_i  (clk_i),
    .we_i   (we),
    .waddr_i(waddr),
    .wdata_i(wdata),
    .raddr_i(raddr),
    .rdata_o(rdata)
  );

  assign busy_o      = (state_q != StIdle);
  assign cfg_ready_o = (state_q == StIdle);

  // shared gap and candidate logic
  logic [FrameW-1:0] gap;
  logic              hi_ok, lo_ok, cand_ok;
  logic [CntW-1:0]   cand;
  assign gap     = rdata - prev_q;
  assign hi_ok   = (rdata != anchor_q) && (rdata != frame_q);
  assign lo_ok   = (prev_q != anchor_q) && (prev_q != frame_q);
  assign cand_ok = hi_ok || lo_ok;
  assign cand    = hi_ok ? idx_q : idx_q - CntW'(1);

  // sequencer
  always_comb begin
    state_d   = state_q;
    count_d   = count_q;
    idx_d     = idx_q;
    pos_d     = pos_q;
    prev_d    = prev_q;
    anchor_d  = anchor_q;
    best_d    = best_q;
    vict_ok_d = vict_ok_q;
    vict_d    = vict_q;
    vkey_d    = vkey_q;
    removed_d = removed_q;
    exists_d  = exists_q;
    we        = 1'b0;
    waddr     = idx_q[AddrW-1:0];
    wdata     = rdata;
    raddr     = idx_q[AddrW-1:0];
    rv_d      = 1'b0;
    res_d     = '0;
    unique case (state_q)
      StIdle: begin
        idx_d = '0;
        pos_d = '0;
        if (start_i) begin
          state_d = StSrchA;
        end
      end
      // walk keys until one exceeds frame
      StSrchA: begin
        if (idx_q >= count_q) begin
          state_d = StDecide;
        end else begin
          state_d = StSrchD;
        end
      end
      StSrchD: begin
        if (rdata <= frame_q) begin
          prev_d  = rdata;
          pos_d   = idx_q + CntW'(1);
          idx_d   = idx_q + CntW'(1);
          state_d = StSrchA;
        end else begin
          state_d = StDecide;
        end
      end
      StDecide: begin
        exists_d = (pos_q != '0) && (prev_q == frame_q);
        state_d  = StDone;
        priority if (mode_q == ModeInsert) begin
          if (!exists_d) begin
            if (count_q >= CapCnt) begin
              rv_d          = 1'b1;
              res_d.refused = 1'b1;
              res_d.last    = 1'b1;
              res_d.entry_count = CountW'(count_q);
              state_d       = StIdle;
            end else begin
              idx_d   = count_q;
              state_d = StInsA;
            end
          end else begin
            state_d = StThin;
          end
        end else if (mode_q == ModeInval) begin
          removed_d = count_q - pos_q;
          count_d   = pos_q;
        end else if (mode_q == ModeClear) begin
          count_d = '0;
        end else begin
        end
      end
      // open a hole at pos, shifting upward
      StInsA: begin
        if (idx_q == pos_q) begin
          we      = 1'b1;
          wdata   = frame_q;
          count_d = count_q + CntW'(1);
          state_d = StThin;
        end else begin
          raddr   = idx_q[AddrW-1:0] - AddrW'(1);
          state_d = StInsD;
        end
      end
      StInsD: begin
        we      = 1'b1;
        idx_d   = idx_q - CntW'(1);
        state_d = StInsA;
      end
      // decide whether another eviction is due
      StThin: begin
        idx_d     = '0;
        vict_ok_d = 1'b0;
        if (maxk_q != '0 && {1'b0, count_q} > (CountW+1)'(maxk_q)) begin
          state_d = StGapA;
        end else begin
          state_d = StDone;
        end
      end
      // scan gaps for the victim
      StGapA: begin
        if (idx_q >= count_q) begin
          if (vict_ok_q) begin
            idx_d   = vict_q;
            state_d = StRemA;
          end else begin
            state_d = StDone;
          end
        end else begin
          state_d = StGapD;
        end
      end
      StGapD: begin
        if (idx_q == '0) begin
          anchor_d = rdata;
        end else if (cand_ok && (!vict_ok_q || gap < best_q)) begin
          vict_ok_d = 1'b1;
          best_d    = gap;
          vict_d    = cand;
          vkey_d    = hi_ok ? rdata : prev_q;
        end
        prev_d  = rdata;
        idx_d   = idx_q + CntW'(1);
        state_d = StGapA;
      end
      // close the victim's slot, then report it
      StRemA: begin
        if (idx_q + CntW'(1) >= count_q) begin
          count_d       = count_q - CntW'(1);
          rv_d          = 1'b1;
          res_d.kind    = KindEvict;
          res_d.key_frame = vkey_q;
          res_d.entry_count = CountW'(count_d);
          state_d       = StThin;
        end else begin
          raddr   = idx_q[AddrW-1:0] + AddrW'(1);
          state_d = StRemD;
        end
      end
      StRemD: begin
        we      = 1'b1;
        idx_d   = idx_q + CntW'(1);
        state_d = StRemA;
      end
      StDone: begin
        rv_d              = 1'b1;
        res_d.kind        = KindDone;
        res_d.last        = 1'b1;
        res_d.entry_count = CountW'(count_q);
        if ((mode_q == ModeSeek) && (pos_q != '0)) begin
          res_d.found     = 1'b1;
          res_d.key_frame = prev_q;
          res_d.distance  = frame_q - prev_q;
        end else if ((mode_q == ModeLookup) && exists_q) begin
          res_d.found     = 1'b1;
          res_d.key_frame = frame_q;
        end else if (mode_q == ModeInval) begin
          res_d.removed_count = CountW'(removed_q);
        end
        state_d = StIdle;
      end
      default: state_d = StIdle;
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      count_q     <= '0;
      maxk_q      <= '0;
      res_valid_o <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      res_valid_o <= rv_d;
      if (cfg_valid_i && cfg_ready_o) begin
        maxk_q <= cfg_data_i;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (state_q == StIdle && start_i) begin
      mode_q  <= in_i.mode;
      frame_q <= in_i.frame;
    end
    idx_q     <= idx_d;
    pos_q     <= pos_d;
    prev_q    <= prev_d;
    anchor_q  <= anchor_d;
    best_q    <= best_d;
    vict_ok_q <= vict_ok_d;
    vict_q    <= vict_d;
    vkey_q    <= vkey_d;
    removed_q <= removed_d;
    exists_q  <= exists_d;
    res_o     <= res_d;
  end

`ifndef SYNTHESIS
  // count never exceeds capacity
  a_count_cap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CapCnt) else $error("key count over capacity");
  // a completion result returns the block to idle
  a_last_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_o && res_o.last) |-> !busy_o) else $error("busy after last");
  // notices never mark last
  a_notice: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_o && res_o.kind) |-> (!res_o.last && busy_o))
    else $error("bad notice");
`endif

endmodule
